FILE: design/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define PFSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pfsp assertion failed");

// Clocked property that is also checked during reset.
`define PFSP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pfsp assertion failed during reset");

`endif

FILE: design/pfsp_pkg.sv
// Package for the parity filter / 7-bit repacker.
// Constants and the parity helper; no dependencies.
package pfsp_pkg;

    localparam int unsigned GROUP_BITS  = 7;
    localparam int unsigned GROUPS      = 8;
    localparam int unsigned OUT_BYTES   = 7;
    localparam int unsigned PACKED_W    = GROUP_BITS * (GROUPS - 1);
    localparam int unsigned FULL_W      = GROUP_BITS * GROUPS;
    localparam int unsigned CNT_W       = 3;

    localparam logic [CNT_W-1:0] LAST_GROUP = CNT_W'(GROUPS - 1);
    localparam logic [CNT_W-1:0] FULL_BYTES = CNT_W'(OUT_BYTES);

    typedef logic [7:0]          t_byte;
    typedef logic [FULL_W-1:0]   t_full;
    typedef logic [PACKED_W-1:0] t_packed;
    typedef logic [CNT_W-1:0]    t_cnt;

    // 1 when the byte has odd parity
    function automatic logic f_odd_parity(input t_byte b);
        return ^b;
    endfunction

endpackage

FILE: design/pfsp_serializer.sv
// Output buffer: holds one packed 56-bit group and sends it out as seven
// bytes, most significant first. Depends on pfsp_pkg.
module pfsp_serializer import pfsp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_full i_data,
    output logic  o_free,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_byte o_out_byte,
    output logic  o_last_of_group
);

    t_full r_buf;
    t_cnt  r_cnt;
    t_full n_buf;
    t_cnt  n_cnt;
    logic  w_xfer;

    assign o_out_valid     = (r_cnt != '0);
    assign w_xfer          = o_out_valid && i_out_ready;
    assign o_free          = (r_cnt == '0) || ((r_cnt == t_cnt'(1)) && i_out_ready);
    assign o_out_byte      = r_buf[FULL_W-1 -: 8];
    assign o_last_of_group = (r_cnt == t_cnt'(1));

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (i_load) begin
            n_buf = i_data;
            n_cnt = FULL_BYTES;
        end else if (w_xfer) begin
            n_buf = {r_buf[FULL_W-9:0], 8'h00};
            n_cnt = r_cnt - t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_buf <= n_buf;
    end

endmodule

FILE: design/parity_filter_seven_bit_packer.sv
// Parity filter and 7-to-8 bit repacker. Accepts one byte per cycle into an
// input register; bytes with odd parity are dropped, even ones contribute
// bits 7..1 to a 49-bit packing register. On the eighth kept byte the full
// 56-bit group moves to the output buffer when free and leaves as seven
// transactions, one per cycle while i_out_ready is high, last one flagged.
// Input is held back only when a group completes while the previous group's
// bytes remain in the single output buffer. Depends on pfsp_pkg, pfsp_serializer.
module parity_filter_seven_bit_packer import pfsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_group
);

    logic    r_in_valid;
    t_byte   r_in_byte;
    t_packed r_packed;
    t_cnt    r_count;
    t_packed n_packed;
    t_cnt    n_count;

    logic    w_even;
    logic    w_emit;
    logic    w_adv;
    logic    w_ser_free;
    t_full   w_full;

    assign w_even     = !f_odd_parity(r_in_byte);
    assign w_emit     = r_in_valid && w_even && (r_count == LAST_GROUP);
    assign w_adv      = !w_emit || w_ser_free;
    assign o_in_ready = w_adv;
    assign w_full     = {r_packed, r_in_byte[7:1]};

    always_comb begin
        n_packed = r_packed;
        n_count  = r_count;
        if (r_in_valid && w_even && w_adv) begin
            if (r_count == LAST_GROUP) begin
                n_packed = '0;
                n_count  = '0;
            end else begin
                n_packed = {r_packed[PACKED_W-GROUP_BITS-1:0], r_in_byte[7:1]};
                n_count  = r_count + t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_packed   <= '0;
            r_count    <= '0;
        end else begin
            if (w_adv) begin
                r_in_valid <= i_in_valid;
            end
            r_packed <= n_packed;
            r_count  <= n_count;
        end
        if (w_adv) begin
            r_in_byte <= i_in_byte;
        end
    end

    pfsp_serializer u_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_emit && w_ser_free),
        .i_data          (w_full),
        .o_free          (w_ser_free),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_group (o_last_of_group)
    );

endmodule

FILE: design/pfsp_checker.sv
// Port-level checker for the parity filter / repacker, bound to the top.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pfsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_group
);

    `PFSP_ASSERT(a_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `PFSP_ASSERT(a_data_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_byte) && $stable(o_last_of_group))
    `PFSP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)
    `PFSP_ASSERT(a_group_continues, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_of_group |=> o_out_valid)
    `PFSP_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid |-> o_in_ready)

endmodule

bind parity_filter_seven_bit_packer pfsp_checker u_pfsp_checker (.*);

FILE: verif/parity_filter_seven_bit_packer_tb.sv
// Self-checking testbench for parity_filter_seven_bit_packer: directed table, then random
// byte stream with random idling on both channels and one long output hold-off.
// Depends on pfsp_pkg and the DUT sources.
`timescale 1ns / 100ps

module parity_filter_seven_bit_packer_tb;
    import pfsp_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_GAP        = 16;
    localparam int TOTAL_ITEMS    = 480;
    localparam int HOLD_AFTER     = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_DIRECTED   = 25;

    typedef struct packed {
        t_byte raw;
        logic  typed;
        t_byte want;
    } t_stim_row;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_out_beat;

    // typed rows complete a group whose seven bytes all equal want
    localparam t_stim_row DIRECTED [NUM_DIRECTED] = '{
        '{8'h01, 1'b0, 8'h00}, '{8'hFE, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00}, '{8'h00, 1'b0, 8'h00}, '{8'h00, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00}, '{8'h00, 1'b0, 8'h00}, '{8'h00, 1'b0, 8'h00},
        '{8'h00, 1'b0, 8'h00}, '{8'h00, 1'b1, 8'h00},
        '{8'hFF, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 8'h00}, '{8'h80, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00}, '{8'hFF, 1'b0, 8'h00},
        '{8'hFF, 1'b1, 8'hFF},
        '{8'h03, 1'b0, 8'h00}, '{8'hC0, 1'b0, 8'h00}, '{8'h81, 1'b0, 8'h00},
        '{8'h55, 1'b0, 8'h00}, '{8'hAA, 1'b0, 8'h00}, '{8'h96, 1'b0, 8'h00}
    };

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic [7:0] i_in_byte       = 8'h00;
    logic       i_out_ready     = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_group;

    // predictor state
    t_cnt      kept_groups = '0;
    t_packed   group_bits  = '0;
    t_out_beat pending_beats [$];

    int  items_sent    = 0;
    int  bytes_dropped = 0;
    int  groups_done   = 0;
    int  beats_checked = 0;
    int  stall_cycles  = 0;
    int  mismatches    = 0;
    int  idle_cycles   = 0;
    bit  send_burst    = 1'b0;
    bit  recv_burst    = 1'b0;
    bit  draining      = 1'b0;
    bit  held_off      = 1'b0;

    parity_filter_seven_bit_packer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_group (o_last_of_group)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void absorb_byte(input t_byte b, input bit typed, input t_byte want);
        t_full     full;
        t_out_beat beat;
        if (^b) begin
            bytes_dropped++;
            return;
        end
        if (kept_groups != LAST_GROUP) begin
            group_bits  = {group_bits[PACKED_W-GROUP_BITS-1:0], b[7:1]};
            kept_groups = kept_groups + 1'b1;
            return;
        end
        full = {group_bits, b[7:1]};
        for (int k = 0; k < OUT_BYTES; k++) begin
            beat.data = typed ? want : full[FULL_W-1-8*k -: 8];
            beat.last = (k == OUT_BYTES - 1);
            pending_beats.push_back(beat);
        end
        kept_groups = '0;
        group_bits  = '0;
        groups_done++;
    endfunction

    function automatic void check_beat(input t_byte data, input logic last);
        t_out_beat exp_beat;
        beats_checked++;
        if (pending_beats.size() == 0) begin
            $display("%0t: unexpected output transaction byte=%02h last=%0b",
                     $time, data, last);
            mismatches++;
            return;
        end
        exp_beat = pending_beats.pop_front();
        if (data !== exp_beat.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, exp_beat.data, data);
            mismatches++;
        end
        if (last !== exp_beat.last) begin
            $display("%0t: last_of_group expected %0b actual %0b", $time, exp_beat.last, last);
            mismatches++;
        end
    endfunction

    task automatic offer_byte(input t_byte b, input bit typed, input t_byte want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        absorb_byte(b, typed, want);
    endtask

    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_ready && i_rst_n)
            stall_cycles <= stall_cycles + 1;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : sink
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held_off && beats_checked >= HOLD_AFTER) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = (recv_burst || draining) ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            check_beat(o_out_byte, o_last_of_group);
            if (beats_checked % 24 == 0)
                recv_burst = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin : source
        t_byte b;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_DIRECTED; r++)
            offer_byte(DIRECTED[r].raw, DIRECTED[r].typed, DIRECTED[r].want);

        // mostly even-parity bytes so groups complete; the rest are random and dropped if odd
        while (items_sent < TOTAL_ITEMS) begin
            b = t_byte'($urandom_range(0, 255));
            if ($urandom_range(0, 3) != 0)
                b[0] = ^b[7:1];
            offer_byte(b, 1'b0, 8'h00);
            if (items_sent % 32 == 0)
                send_burst = ($urandom_range(0, 2) == 0);
        end
        i_in_valid <= 1'b0;
        draining = 1'b1;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes (%0d dropped for odd parity), %0d groups packed.",
                 items_sent, bytes_dropped, groups_done);
        $display("Checked %0d output transactions; input stalled for %0d cycles.",
                 beats_checked, stall_cycles);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
